/* rtl/cba_pkg.sv */
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants for the circuit breaker admission gate: event
// codes, reject codes, register indexes and the beat payload structs.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Event codes carried in the action field of an input beat.
  typedef enum logic [2:0] {
    ACT_SUBMIT   = 3'd0,
    ACT_COMPLETE = 3'd1,
    ACT_ABANDON  = 3'd2,
    ACT_RESET    = 3'd3,
    ACT_TICK     = 3'd4,
    ACT_QUERY    = 3'd5
  } action_t;

  // Reasons a submit is refused.
  typedef enum logic [1:0] {
    RSN_NONE      = 2'd0,
    RSN_OPEN      = 2'd1,
    RSN_SATURATED = 2'd2
  } reason_t;

  // Configuration port geometry and register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WINDOW    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_FLY   = 2'd2;

  // Register reset values.
  localparam logic [7:0]  THRESHOLD_RST = 8'd5;
  localparam logic [31:0] WINDOW_RST    = 32'd30000;
  localparam logic [7:0]  MAX_FLY_RST   = 8'd4;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]  trip_level;
    logic [31:0] recovery_window;
    logic [7:0]  fly_cap;
  } cfg_t;

  // Input beat payload.
  typedef struct packed {
    logic [2:0] action;
    logic       succeeded;
    logic       was_abandoned;
  } in_item_t;

  // Result beat payload.
  typedef struct packed {
    logic       accepted;
    logic [1:0] reject_reason;
    logic       is_available;
    logic       open_now;
    logic [7:0] outstanding;
    logic [7:0] failure_streak;
  } out_item_t;

endpackage

/* rtl/cba_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cba_cfg_regs
// Configuration register file: decodes the write port into the threshold,
// recovery window and in-flight cap registers.
// ----------------------------------------------------------------------------
module cba_cfg_regs
  import cba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Address decode; an index past the last register is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_THRESHOLD: cfg_nxt.trip_level      = cfg_wdata[7:0];
        CFG_IDX_WINDOW:    cfg_nxt.recovery_window = cfg_wdata[31:0];
        CFG_IDX_MAX_FLY:   cfg_nxt.fly_cap         = cfg_wdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trip_level      <= THRESHOLD_RST;
      cfg_r.recovery_window <= WINDOW_RST;
      cfg_r.fly_cap         <= MAX_FLY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/cba_in_stage.sv */
// ----------------------------------------------------------------------------
// cba_in_stage
// Input register: captures one accepted beat and holds it until the
// decision stage consumes it.
// ----------------------------------------------------------------------------
module cba_in_stage
  import cba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     item_valid,
  input  logic     item_take,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  // The register is free when empty or being drained this cycle.
  assign in_ready  = !valid_r || item_take;
  assign valid_nxt = in_valid || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

/* rtl/cba_core.sv */
// ----------------------------------------------------------------------------
// cba_core
// Breaker state and the decision logic: applies one event to the in-flight
// count, failure streak, open flag and open timer, and forms the result.
// ----------------------------------------------------------------------------
module cba_core
  import cba_pkg::*;
#(
  parameter int COUNT_WIDTH = 8,
  parameter int TIMER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  // Compare widths wide enough for both the state and the register.
  localparam int CNT_CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam int TMR_CMP_W = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  logic [COUNT_WIDTH-1:0] fly_r, fly_nxt;
  logic [COUNT_WIDTH-1:0] fail_r, fail_nxt;
  logic                   open_r, open_nxt;
  logic [TIMER_WIDTH-1:0] ticks_r, ticks_nxt;

  logic                   expired;
  logic                   open_pre;
  logic [COUNT_WIDTH-1:0] fail_pre;
  logic [COUNT_WIDTH-1:0] fail_inc;
  logic                   trip;
  logic                   fly_full;
  logic                   fly_full_nxt;
  logic                   accepted;
  reason_t                reason;

  // Recovery window has run out for an open circuit.
  assign expired = open_r &&
                   (TMR_CMP_W'(ticks_r) > TMR_CMP_W'(cfg.recovery_window));

  // Submit and query close an expired circuit before anything else.
  always_comb begin
    open_pre = open_r;
    fail_pre = fail_r;
    if ((item.action == ACT_SUBMIT || item.action == ACT_QUERY) && expired) begin
      open_pre = 1'b0;
      fail_pre = '0;
    end
  end

  // Saturating failure increment and the threshold test it feeds.
  assign fail_inc = (fail_r != COUNT_MAX) ? fail_r + 1'b1 : fail_r;
  assign trip     = CNT_CMP_W'(fail_inc) >= CNT_CMP_W'(cfg.trip_level);
  assign fly_full = CNT_CMP_W'(fly_r) >= CNT_CMP_W'(cfg.fly_cap);

  // Event decode.
  always_comb begin
    fly_nxt   = fly_r;
    fail_nxt  = fail_pre;
    open_nxt  = open_pre;
    ticks_nxt = ticks_r;
    accepted  = 1'b0;
    reason    = RSN_NONE;
    unique case (item.action)
      ACT_SUBMIT: begin
        if (open_pre) begin
          reason = RSN_OPEN;
        end else if (fly_full) begin
          reason = RSN_SATURATED;
        end else begin
          accepted = 1'b1;
          if (fly_r != COUNT_MAX) begin
            fly_nxt = fly_r + 1'b1;
          end
        end
      end
      ACT_COMPLETE: begin
        if (fly_r != '0) begin
          fly_nxt = fly_r - 1'b1;
        end
        if (!item.succeeded) begin
          fail_nxt = fail_inc;
          if (trip) begin
            open_nxt  = 1'b1;
            ticks_nxt = '0;
          end
        end else if (!item.was_abandoned) begin
          fail_nxt = '0;
        end
      end
      ACT_ABANDON: begin
        fail_nxt = fail_inc;
        if (trip) begin
          open_nxt  = 1'b1;
          ticks_nxt = '0;
        end
      end
      ACT_RESET: begin
        open_nxt = 1'b0;
        fail_nxt = '0;
        fly_nxt  = '0;
      end
      ACT_TICK: begin
        if (open_r && ticks_r != TIMER_MAX) begin
          ticks_nxt = ticks_r + 1'b1;
        end
      end
      ACT_QUERY: begin
        // Only the expiry check above applies.
      end
      default: begin
        // Unused codes leave the state alone.
      end
    endcase
  end

  assign fly_full_nxt = CNT_CMP_W'(fly_nxt) >= CNT_CMP_W'(cfg.fly_cap);

  // Result as seen after this event.
  always_comb begin
    result.accepted       = accepted;
    result.reject_reason  = reason;
    result.is_available   = !open_nxt && !fly_full_nxt;
    result.open_now       = open_nxt;
    result.outstanding    = 8'(fly_nxt);
    result.failure_streak = 8'(fail_nxt);
  end

  // State update on each consumed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fly_r   <= '0;
      fail_r  <= '0;
      open_r  <= 1'b0;
      ticks_r <= '0;
    end else if (step) begin
      fly_r   <= fly_nxt;
      fail_r  <= fail_nxt;
      open_r  <= open_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule

/* rtl/cba_out_stage.sv */
// ----------------------------------------------------------------------------
// cba_out_stage
// Result register: holds one result beat until the consumer takes it and
// tells the decision stage when it may advance.
// ----------------------------------------------------------------------------
module cba_out_stage
  import cba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  output logic      res_ready,
  input  out_item_t res_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // Room when empty or when the held beat leaves this cycle.
  assign res_ready = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/circuit_breaker_admission.sv */
// Flow: the decision logic reads the beat held in the input register, and its result
// is captured in the result register; a full result register stalls the input register.
// Throughput: one beat per cycle while out_ready is high; the input register feeds
// combinational decision logic straight into the result register, so beats stream freely.
// Reset: synchronous, active low; clears the counters, breaker and timer,
// empties both registers and restores threshold 5, window 30000 and cap 4.
// ----------------------------------------------------------------------------
// circuit_breaker_admission
// Admission gate combining a circuit breaker with a cap on requests in
// flight, driven by submit, complete, abandon, reset, tick and query events.
// ----------------------------------------------------------------------------
module circuit_breaker_admission
  import cba_pkg::*;
#(
  parameter int COUNT_WIDTH = 8,
  parameter int TIMER_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  cfg_t      cfg;
  logic      item_valid;
  logic      res_ready;
  logic      step;
  in_item_t  item;
  out_item_t result;

  // A beat moves from the input register to the result register.
  assign step = item_valid && res_ready;

  cba_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cba_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_take  (res_ready),
    .item       (item)
  );

  cba_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (step),
    .item   (item),
    .result (result)
  );

  cba_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_ready (res_ready),
    .res_data  (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
